>>> rtl/core/gfp_pkg.sv
// Package with the shared widths and defaults of the first-fit placer.
`timescale 1ns / 1ps
package gfp_pkg;
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 256;
    localparam int ROLL_W       = 7;
    localparam int PW_W         = 7;
    localparam int PH_W         = 8;
    localparam int ROW_OUT_W    = 8;
    localparam int COL_OUT_W    = 6;
    localparam int LEN_OUT_W    = 9;
    localparam logic [ROLL_W-1:0] ROLL_RESET = 7'd64;
endpackage

>>> rtl/core/gfp_if.sv
// Handshake interfaces for the piece, result and configuration channels.
`timescale 1ns / 1ps
interface gfp_piece_if;
    import gfp_pkg::*;
    logic valid;
    logic ready;
    logic [PW_W-1:0] piece_width;
    logic [PH_W-1:0] piece_height;
    logic first_piece;
    modport source (output valid, piece_width, piece_height, first_piece, input ready);
    modport sink (input valid, piece_width, piece_height, first_piece, output ready);
endinterface

interface gfp_result_if;
    import gfp_pkg::*;
    logic valid;
    logic ready;
    logic [ROW_OUT_W-1:0] top_row;
    logic [COL_OUT_W-1:0] left_col;
    logic [ROW_OUT_W-1:0] bottom_row;
    logic [COL_OUT_W-1:0] right_col;
    logic [LEN_OUT_W-1:0] used_length;
    logic error;
    modport source (output valid, top_row, left_col, bottom_row, right_col, used_length,
                    error, input ready);
    modport sink (input valid, top_row, left_col, bottom_row, right_col, used_length,
                  error, output ready);
endinterface

interface gfp_cfg_if;
    import gfp_pkg::*;
    logic valid;
    logic ready;
    logic [ROLL_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/grid_rectangle_first_fit_placer.sv
// Top level of the first-fit rectangle placer with its scan sequencer.
// One piece is handled at a time. The canvas lives in a RAM of one row per
// entry. For each valid piece the sequencer reads the row at the cursor and
// steps over its columns, checks each row under a candidate column, marks the
// rows it takes and then issues the word, so time depends on how full the
// canvas is. A new piece is taken while the previous result word still waits
// on the output.
`timescale 1ns / 1ps
module grid_rectangle_first_fit_placer #(
    parameter int MAX_COLS = gfp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gfp_pkg::MAX_ROWS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    gfp_piece_if.sink    piece,
    gfp_result_if.source result,
    gfp_cfg_if.sink      cfg
);
    import gfp_pkg::*;

    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW = $clog2(MAX_ROWS);
    localparam int RW  = RIW + 1;
    localparam int SW  = ((RW > 8) ? RW : 8) + 1;
    localparam int LW  = $clog2(MAX_ROWS + 1);
    localparam logic [ROLL_W-1:0] MAXC = ROLL_W'(MAX_COLS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDB  = 4'd1;
    localparam logic [3:0] ST_EVB  = 4'd2;
    localparam logic [3:0] ST_STEP = 4'd3;
    localparam logic [3:0] ST_CKRD = 4'd4;
    localparam logic [3:0] ST_CKEV = 4'd5;
    localparam logic [3:0] ST_MKRD = 4'd6;
    localparam logic [3:0] ST_MKWR = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]          state_reg;
    logic [ROLL_W-1:0]   roll_reg;
    logic [RIW-1:0]      cur_row_reg;
    logic [CIW-1:0]      cur_col_reg;
    logic [LW-1:0]       len_reg;
    logic [MAX_ROWS-1:0] valid_reg;
    logic [PW_W-1:0]     pw_reg;
    logic [PH_W-1:0]     ph_reg;
    logic [RW-1:0]       row_reg;
    logic [ROLL_W-1:0]   col_reg;
    logic [RIW-1:0]      k_reg;
    logic [RIW-1:0]      rd_row_reg;
    logic [MAX_COLS-1:0] base_reg;
    logic [MAX_COLS-1:0] mask_reg;
    logic                err_reg;

    logic [ROLL_W-1:0]   w_eff;
    logic [MAX_COLS-1:0] rdata;
    logic [MAX_COLS-1:0] rdata_eff;
    logic [MAX_COLS-1:0] mask_next;
    logic [SW-1:0]       row_end;
    logic                too_deep;
    logic                col_over;
    logic                last_k;
    logic                slot_free;
    logic                ram_re;
    logic                ram_we;
    logic [RIW-1:0]      ram_raddr;
    logic [LW+8:0]       len_ext;
    logic [RW+7:0]       top_ext;
    logic [SW+7:0]       bot_ext;
    logic [ROLL_W+5:0]   left_ext;
    logic [ROLL_W+5:0]   right_ext;
    logic [ROLL_W:0]     right_col;

    assign w_eff     = (roll_reg > MAXC) ? MAXC : roll_reg;
    assign rdata_eff = valid_reg[rd_row_reg] ? rdata : '0;
    assign mask_next = ({MAX_COLS{1'b1}} >> (MAXC - pw_reg)) << col_reg[CIW-1:0];
    assign row_end   = SW'(row_reg) + SW'(ph_reg);
    assign too_deep  = (row_reg >= RW'(MAX_ROWS)) || (row_end > SW'(MAX_ROWS));
    assign col_over  = ({1'b0, col_reg} + {1'b0, pw_reg}) > {1'b0, w_eff};
    assign last_k    = (SW'(k_reg) + SW'(1)) == row_end;
    assign slot_free = !result.valid || result.ready;
    assign right_col = {1'b0, col_reg} + {1'b0, pw_reg} - (ROLL_W + 1)'(1);

    assign len_ext   = {9'b0, len_reg};
    assign top_ext   = {8'b0, row_reg};
    assign bot_ext   = {8'b0, row_end - SW'(1)};
    assign left_ext  = {6'b0, col_reg};
    assign right_ext = {5'b0, right_col};

    assign piece.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    assign ram_re    = (state_reg == ST_RDB && !too_deep) || (state_reg == ST_CKRD)
                       || (state_reg == ST_MKRD);
    assign ram_raddr = (state_reg == ST_RDB) ? row_reg[RIW-1:0] : k_reg;
    assign ram_we    = (state_reg == ST_MKWR);

    gfp_ram #(
        .WIDTH(MAX_COLS),
        .DEPTH(MAX_ROWS)
    ) u_canvas (
        .clk  (clk),
        .we   (ram_we),
        .waddr(k_reg),
        .wdata(rdata_eff | mask_reg),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            roll_reg     <= ROLL_RESET;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            len_reg      <= '0;
            valid_reg    <= '0;
            result.valid <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                roll_reg <= cfg.data;
            end
            if (result.valid && result.ready && state_reg != ST_OUT)
            begin
                result.valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (piece.valid)
                    begin
                        pw_reg  <= piece.piece_width;
                        ph_reg  <= piece.piece_height;
                        row_reg <= RW'(piece.first_piece ? '0 : cur_row_reg);
                        col_reg <= ROLL_W'(piece.first_piece ? '0 : cur_col_reg);
                        if (piece.first_piece)
                        begin
                            cur_row_reg <= '0;
                            cur_col_reg <= '0;
                            len_reg     <= '0;
                            valid_reg   <= '0;
                        end
                        if (piece.piece_width == '0 || piece.piece_height == '0
                            || piece.piece_width > w_eff)
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            err_reg   <= 1'b0;
                            state_reg <= ST_RDB;
                        end
                    end
                end
                ST_RDB:
                begin
                    rd_row_reg <= row_reg[RIW-1:0];
                    if (too_deep)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_EVB;
                    end
                end
                ST_EVB:
                begin
                    base_reg  <= rdata_eff;
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    if (col_over || (base_reg[col_reg[CIW-1:0]]
                        && col_reg == w_eff - ROLL_W'(1)))
                    begin
                        row_reg   <= row_reg + RW'(1);
                        col_reg   <= '0;
                        state_reg <= ST_RDB;
                    end
                    else if (base_reg[col_reg[CIW-1:0]])
                    begin
                        col_reg <= col_reg + ROLL_W'(1);
                    end
                    else
                    begin
                        k_reg     <= row_reg[RIW-1:0];
                        mask_reg  <= mask_next;
                        state_reg <= ST_CKRD;
                    end
                end
                ST_CKRD:
                begin
                    rd_row_reg <= k_reg;
                    state_reg  <= ST_CKEV;
                end
                ST_CKEV:
                begin
                    if ((rdata_eff & mask_reg) != '0)
                    begin
                        col_reg   <= col_reg + ROLL_W'(1);
                        state_reg <= ST_STEP;
                    end
                    else if (last_k)
                    begin
                        k_reg     <= row_reg[RIW-1:0];
                        state_reg <= ST_MKRD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + RIW'(1);
                        state_reg <= ST_CKRD;
                    end
                end
                ST_MKRD:
                begin
                    rd_row_reg <= k_reg;
                    state_reg  <= ST_MKWR;
                end
                ST_MKWR:
                begin
                    valid_reg[k_reg] <= 1'b1;
                    if (last_k)
                    begin
                        if (row_end > SW'(len_reg))
                        begin
                            len_reg <= LW'(row_end);
                        end
                        cur_row_reg <= row_reg[RIW-1:0];
                        cur_col_reg <= CIW'(right_col);
                        state_reg   <= ST_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + RIW'(1);
                        state_reg <= ST_MKRD;
                    end
                end
                ST_OUT:
                begin
                    if (slot_free)
                    begin
                        result.valid <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && slot_free)
        begin
            result.used_length <= len_ext[8:0];
            result.error       <= err_reg;
            result.top_row     <= err_reg ? '0 : top_ext[7:0];
            result.left_col    <= err_reg ? '0 : left_ext[5:0];
            result.bottom_row  <= err_reg ? '0 : bot_ext[7:0];
            result.right_col   <= err_reg ? '0 : right_ext[5:0];
        end
    end

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error |-> result.top_row == '0 && result.left_col == '0
        && result.bottom_row == '0 && result.right_col == '0)
        else $error("Error word carries nonzero corners.");
    a_cols_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.error |-> result.right_col >= result.left_col)
        else $error("Placed piece has right column left of its left column.");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_ROWS))
        else $error("Used length exceeds the grid depth.");
    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_col_reg) < MAX_COLS)
        else $error("Cursor column lies outside the grid.");
`endif
endmodule

>>> rtl/core/gfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gfp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> tb/grid_rectangle_first_fit_placer_test.sv
// Testbench that places random and directed pieces and checks every result word.
`timescale 1ns / 1ps
module grid_rectangle_first_fit_placer_test;
    import gfp_pkg::*;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] top_row;
        logic [COL_OUT_W-1:0] left_col;
        logic [ROW_OUT_W-1:0] bottom_row;
        logic [COL_OUT_W-1:0] right_col;
        logic [LEN_OUT_W-1:0] used_length;
        logic                 error;
    } placement_t;

    class placement_scoreboard;
        logic [63:0] occupancy [256];
        int unsigned scan_row;
        int unsigned scan_col;
        int unsigned length_so_far;
        int unsigned roll;
        placement_t pending [$];
        int errors;

        function void wipe();
            foreach (occupancy[i])
                occupancy[i] = '0;
            scan_row = 0;
            scan_col = 0;
            length_so_far = 0;
        endfunction

        function void note_piece(int unsigned pw, int unsigned ph, bit first);
            int unsigned w, row, col, r;
            logic [63:0] bits, mask;
            bit ok, clash;
            placement_t p;
            w = roll > 64 ? 64 : roll;
            ok = 0;
            mask = '0;
            if (first)
                wipe();
            row = scan_row;
            col = scan_col;
            if (pw != 0 && ph != 0 && pw <= w) begin
                bits = (pw >= 64) ? '1 : ((64'd1 << pw) - 64'd1);
                forever begin
                    if (row >= 256 || row + ph > 256)
                        break;
                    if (col + pw > w) begin
                        row++;
                        col = 0;
                    end
                    else if (occupancy[row][col]) begin
                        if (col == w - 1) begin
                            row++;
                            col = 0;
                        end
                        else
                            col++;
                    end
                    else begin
                        mask = bits << col;
                        clash = 0;
                        for (r = row; r < row + ph; r++)
                            if ((occupancy[r] & mask) != 0)
                                clash = 1;
                        if (!clash) begin
                            ok = 1;
                            break;
                        end
                        col++;
                    end
                end
            end
            p = '0;
            if (!ok) begin
                p.used_length = LEN_OUT_W'(length_so_far);
                p.error = 1;
            end
            else begin
                for (r = row; r < row + ph; r++)
                    occupancy[r] |= mask;
                if (row + ph > length_so_far)
                    length_so_far = row + ph;
                p.top_row = ROW_OUT_W'(row);
                p.left_col = COL_OUT_W'(col);
                p.bottom_row = ROW_OUT_W'(row + ph - 1);
                p.right_col = COL_OUT_W'(col + pw - 1);
                p.used_length = LEN_OUT_W'(length_so_far);
                scan_row = row;
                scan_col = col + pw - 1;
            end
            pending.insert(pending.size(), p);
        endfunction

        task report(string what, int got, int want);
            $display("Mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(placement_t got);
            placement_t want;
            if (pending.size() == 0)
            begin
                report("outstanding pieces", 0, 1);
            end
            else
            begin
                want = pending.pop_front();
                if (got.top_row !== want.top_row)
                    report("top_row", got.top_row, want.top_row);
                if (got.left_col !== want.left_col)
                    report("left_col", got.left_col, want.left_col);
                if (got.bottom_row !== want.bottom_row)
                    report("bottom_row", got.bottom_row, want.bottom_row);
                if (got.right_col !== want.right_col)
                    report("right_col", got.right_col, want.right_col);
                if (got.used_length !== want.used_length)
                    report("used_length", got.used_length, want.used_length);
                if (got.error !== want.error)
                    report("error", got.error, want.error);
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    gfp_piece_if  piece();
    gfp_result_if result();
    gfp_cfg_if    cfg();
    placement_scoreboard board;

    grid_rectangle_first_fit_placer u_top (
        .clk(clk), .rst_n(rst_n), .piece(piece), .result(result), .cfg(cfg)
    );

    always
    begin
        clk = 0;
        #1;
        clk = 1;
        #1;
    end

    task send_piece(int unsigned pw, int unsigned ph, bit first);
        int unsigned gap;
        gap = $urandom_range(0, 6);
        if (gap != 0)
        begin
            piece.valid <= 0;
            repeat (gap)
                @(posedge clk);
        end
        piece.valid <= 1;
        piece.piece_width <= PW_W'(pw);
        piece.piece_height <= PH_W'(ph);
        piece.first_piece <= first;
        do
            @(posedge clk);
        while (!piece.ready);
        board.note_piece(pw, ph, first);
    endtask

    task drain();
        piece.valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (600)
            @(posedge clk);
    endtask

    task write_roll(int unsigned value);
        drain();
        cfg.valid <= 1;
        cfg.data <= ROLL_W'(value);
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 0;
        board.roll = value;
    endtask

    task random_phase(int unsigned count, int unsigned roll);
        int unsigned k, pw, ph, cap;
        for (k = 0; k < count; k++)
        begin
            cap = roll == 0 ? 1 : roll;
            case ($urandom_range(0, 9))
                0: pw = $urandom_range(0, 127);
                1: pw = cap;
                default: pw = $urandom_range(1, cap > 16 ? 16 : cap);
            endcase
            case ($urandom_range(0, 9))
                0: ph = $urandom_range(0, 255);
                1: ph = $urandom_range(100, 255);
                default: ph = $urandom_range(1, 12);
            endcase
            send_piece(pw, ph, $urandom_range(0, 24) == 0);
        end
    endtask

    always @(posedge clk)
    begin
        placement_t got;
        if (result.valid && result.ready)
        begin
            got.top_row = result.top_row;
            got.left_col = result.left_col;
            got.bottom_row = result.bottom_row;
            got.right_col = result.right_col;
            got.used_length = result.used_length;
            got.error = result.error;
            board.check_word(got);
        end
    end

    initial
    begin
        int unsigned stall;
        result.ready <= 0;
        wait (rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                result.ready <= 0;
                repeat (stall)
                    @(posedge clk);
            end
            result.ready <= 1;
            do
                @(posedge clk);
            while (!result.valid);
        end
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        board = new();
        board.wipe();
        board.roll = ROLL_RESET;
        board.errors = 0;
        piece.valid <= 0;
        piece.piece_width <= 0;
        piece.piece_height <= 0;
        piece.first_piece <= 0;
        cfg.valid <= 0;
        cfg.data <= 0;
        rst_n <= 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_piece(64, 1, 1);
        send_piece(1, 1, 0);
        send_piece(1, 255, 0);
        send_piece(0, 4, 0);
        send_piece(5, 0, 0);
        send_piece(65, 2, 0);
        send_piece(127, 2, 0);
        send_piece(32, 255, 1);
        send_piece(33, 2, 0);
        send_piece(32, 2, 0);
        send_piece(3, 255, 0);
        send_piece(1, 1, 1);
        drain();
        write_roll(0);
        send_piece(1, 1, 0);
        send_piece(64, 8, 1);
        write_roll(127);
        send_piece(64, 3, 0);
        send_piece(64, 1, 0);
        write_roll(1);
        send_piece(1, 2, 0);
        send_piece(2, 1, 0);
        write_roll(10);
        send_piece(4, 3, 1);
        send_piece(4, 3, 0);
        send_piece(4, 3, 0);

        random_phase(500, 10);
        write_roll(64);
        random_phase(500, 64);
        write_roll(1);
        random_phase(150, 1);
        write_roll(37);
        random_phase(400, 37);
        write_roll(100);
        random_phase(300, 64);

        drain();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
